### sv/i2c_ram_pkg.sv
// ----------------------------------------------------------------------------
// i2c_ram_pkg - shared types and constants of the i2c register access master
// Holds the command codes, the reset address and the result record that the
// controller hands to the top level.
// ----------------------------------------------------------------------------
package i2c_ram_pkg;

  // default depth of the write byte buffer
  localparam int unsigned MAX_BYTES_DEF = 16;

  // target address after reset
  localparam logic [6:0] DEV_ADDR_RESET = 7'd54;

  // command codes carried with each input transfer
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // one result record, produced for every accepted input transfer
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
    logic       error;
  } result_t;

endpackage

### sv/i2c_register_access_master.sv
// ----------------------------------------------------------------------------
// i2c_register_access_master - bit-level i2c master for register access
// Sequences register writes and register reads one bus delay segment per
// tick and reports the driven SCL and SDA levels.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side transfer carries one command: a tick, a write byte push,
//   a write start or a read start. Pushes and starts are taken while idle;
//   while busy only ticks advance the bus, other commands pass as no-ops.
//   Every accepted command yields exactly one master-side transfer with the
//   SCL/SDA levels, busy, any received byte (tlast marks the final one) and
//   the done/error flags of a finished transaction.
//   The result is registered: it appears in the cycle after acceptance and a
//   new command is taken every cycle while results are taken, so throughput
//   is one command per clock, set by the single sequencer register stage.
//   When the master side stalls, the result is held and s_axis_tready falls
//   until it is taken; no result is lost or repeated.
//   The device address is written through the cfg channel, which is always
//   ready; write it only while idle.
//   Reset: bus released (SCL and SDA high), idle, write buffer empty,
//   device address 54. Buffer entries hold no defined value until pushed.
// ----------------------------------------------------------------------------
module i2c_register_access_master #(
  parameter int unsigned MaxBytes = i2c_ram_pkg::MAX_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_addr[7:0], data_byte[15:8], byte_count[20:16], sda_in[21], zero[23:22]
  input  logic [23:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_level[0], sda_level[1], busy_res[2], read_valid[3], read_data[11:4],
  // done_res[12], error[13], zero[15:14]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // device address write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned IdxW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;

  i2c_ram_pkg::result_t res;
  logic                 buf_we;
  logic [IdxW-1:0]      buf_waddr;
  logic [7:0]           buf_wdata;
  logic [IdxW-1:0]      buf_raddr;
  logic [7:0]           buf_rdata;

  assign cfg_ready_o = 1'b1;

  // sequencer with result register
  i2c_ram_fsm #(
    .MaxBytes (MaxBytes)
  ) u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tuser),
    .reg_addr_i   (s_axis_tdata[7:0]),
    .data_byte_i  (s_axis_tdata[15:8]),
    .byte_count_i (s_axis_tdata[20:16]),
    .sda_in_i     (s_axis_tdata[21]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .res_o        (res),
    .buf_we_o     (buf_we),
    .buf_waddr_o  (buf_waddr),
    .buf_wdata_o  (buf_wdata),
    .buf_raddr_o  (buf_raddr),
    .buf_rdata_i  (buf_rdata)
  );

  // write byte buffer
  i2c_ram_wbuf #(
    .MaxBytes (MaxBytes)
  ) u_wbuf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // result packing
  assign m_axis_tdata = {2'b00, res.error, res.done_res, res.read_data, res.read_valid,
                         res.busy_res, res.sda_level, res.scl_level};
  assign m_axis_tlast = res.read_last;

endmodule

### sv/i2c_ram_wbuf.sv
// ----------------------------------------------------------------------------
// i2c_ram_wbuf - write byte buffer
// Single write port, one registered read port that follows the send index.
// ----------------------------------------------------------------------------
module i2c_ram_wbuf #(
  parameter int unsigned MaxBytes = i2c_ram_pkg::MAX_BYTES_DEF,
  localparam int unsigned IdxW    = (MaxBytes > 1) ? $clog2(MaxBytes) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [7:0]      wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [7:0]      rdata_o
);

  logic [7:0] mem_q [MaxBytes];
  logic [7:0] rdata_q;

  // byte store, filled while the controller is idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data follows the address in the next cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/i2c_ram_fsm.sv
// ----------------------------------------------------------------------------
// i2c_ram_fsm - bus sequencer of the i2c register access master
// Advances one bus delay segment per tick transfer and registers the result
// record of every accepted transfer.
// ----------------------------------------------------------------------------
module i2c_ram_fsm #(
  parameter int unsigned MaxBytes = i2c_ram_pkg::MAX_BYTES_DEF,
  localparam int unsigned IdxW    = (MaxBytes > 1) ? $clog2(MaxBytes) : 1,
  localparam int unsigned CntW    = $clog2(MaxBytes + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command transfer
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          reg_addr_i,
  input  logic [7:0]          data_byte_i,
  input  logic [4:0]          byte_count_i,
  input  logic                sda_in_i,
  // configuration
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_data_i,
  // result transfer
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2c_ram_pkg::result_t res_o,
  // write buffer
  output logic                buf_we_o,
  output logic [IdxW-1:0]     buf_waddr_o,
  output logic [7:0]          buf_wdata_o,
  output logic [IdxW-1:0]     buf_raddr_o,
  input  logic [7:0]          buf_rdata_i
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_SEND,
    PH_WACK,
    PH_RECV,
    PH_RACK,
    PH_STOP
  } phase_e;

  typedef enum logic [2:0] {
    ST_ADDR_W,
    ST_REG,
    ST_DATA,
    ST_ADDR_R,
    ST_READ
  } stage_e;

  phase_e              phase_q, phase_d;
  stage_e              stage_q, stage_d;
  logic [1:0]          seg_q, seg_d;
  logic [3:0]          bit_cnt_q, bit_cnt_d;
  logic [7:0]          shift_q, shift_d;
  logic [CntW-1:0]     left_q, left_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [CntW-1:0]     index_q, index_d;
  logic                is_read_q, is_read_d;
  logic [7:0]          reg_q, reg_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                err_q, err_d;
  logic [6:0]          dev_addr_q;
  logic                out_valid_q;
  i2c_ram_pkg::result_t res_q, res_d;
  i2c_ram_pkg::op_e    op;
  logic                accept;
  logic [CntW-1:0]     count_sat;

  assign op          = i2c_ram_pkg::op_e'(op_i);
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // buffer ports: push at the fill count, read at the send index
  assign buf_we_o    = accept && (phase_q == PH_IDLE) && (op == i2c_ram_pkg::OP_PUSH) &&
                       (fill_q < CntW'(MaxBytes));
  assign buf_waddr_o = fill_q[IdxW-1:0];
  assign buf_wdata_o = data_byte_i;
  assign buf_raddr_o = index_q[IdxW-1:0];

  // byte count limited to the buffer depth
  always_comb begin
    if (int'(byte_count_i) > int'(MaxBytes)) begin
      count_sat = CntW'(MaxBytes);
    end else begin
      count_sat = CntW'(byte_count_i);
    end
  end

  // next state and result of one transfer
  always_comb begin
    phase_d   = phase_q;
    stage_d   = stage_q;
    seg_d     = seg_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    left_d    = left_q;
    fill_d    = fill_q;
    index_d   = index_q;
    is_read_d = is_read_q;
    reg_d     = reg_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    err_d     = err_q;
    res_d     = '0;

    if (phase_q == PH_IDLE) begin
      case (op)
        i2c_ram_pkg::OP_PUSH: begin
          if (fill_q < CntW'(MaxBytes)) begin
            fill_d = fill_q + CntW'(1);
          end
        end
        i2c_ram_pkg::OP_WRITE, i2c_ram_pkg::OP_READ: begin
          if (op == i2c_ram_pkg::OP_WRITE) begin
            fill_d = '0;
          end
          is_read_d = (op == i2c_ram_pkg::OP_READ);
          reg_d     = reg_addr_i;
          left_d    = count_sat;
          index_d   = '0;
          err_d     = 1'b0;
          stage_d   = ST_ADDR_W;
          phase_d   = PH_START;
          seg_d     = 2'd0;
          bit_cnt_d = 4'd0;
        end
        default: ;
      endcase
    end else if (op == i2c_ram_pkg::OP_TICK) begin
      unique case (phase_q)
        PH_START: begin
          if (seg_q == 2'd0) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
            seg_d = 2'd1;
          end else if (seg_q == 2'd1) begin
            sda_d = 1'b0;
            seg_d = 2'd2;
          end else begin
            scl_d     = 1'b0;
            phase_d   = PH_SEND;
            shift_d   = {dev_addr_q, stage_q == ST_ADDR_R};
            bit_cnt_d = 4'd0;
            seg_d     = 2'd0;
          end
        end
        PH_SEND: begin
          if (seg_q == 2'd0) begin
            sda_d = shift_q[7];
            seg_d = 2'd1;
          end else if (seg_q == 2'd1) begin
            scl_d = 1'b1;
            seg_d = 2'd2;
          end else begin
            scl_d     = 1'b0;
            shift_d   = {shift_q[6:0], 1'b0};
            bit_cnt_d = bit_cnt_q + 4'd1;
            seg_d     = 2'd0;
            if (bit_cnt_q == 4'd7) begin
              sda_d     = 1'b1;
              phase_d   = PH_WACK;
              bit_cnt_d = 4'd0;
            end
          end
        end
        PH_WACK: begin
          if (seg_q == 2'd0) begin
            sda_d = 1'b1;
            seg_d = 2'd1;
          end else if (seg_q == 2'd1) begin
            scl_d = 1'b1;
            seg_d = 2'd2;
          end else begin
            scl_d     = 1'b0;
            seg_d     = 2'd0;
            bit_cnt_d = 4'd0;
            // acknowledge handling per stage of the transaction
            case (stage_q)
              ST_ADDR_W: begin
                if (sda_in_i) begin
                  err_d   = 1'b1;
                  phase_d = PH_STOP;
                end else begin
                  stage_d = ST_REG;
                  phase_d = PH_SEND;
                  shift_d = reg_q;
                end
              end
              ST_REG, ST_DATA: begin
                if (stage_q == ST_REG && is_read_q) begin
                  stage_d = ST_ADDR_R;
                  phase_d = PH_START;
                end else if (stage_q == ST_DATA && sda_in_i) begin
                  err_d   = 1'b1;
                  phase_d = PH_STOP;
                end else begin
                  stage_d = ST_DATA;
                  if (left_q == '0) begin
                    phase_d = PH_STOP;
                  end else begin
                    phase_d = PH_SEND;
                    shift_d = buf_rdata_i;
                    index_d = index_q + CntW'(1);
                    left_d  = left_q - CntW'(1);
                  end
                end
              end
              default: begin
                stage_d = ST_READ;
                if (left_q != '0) begin
                  phase_d = PH_RECV;
                  shift_d = 8'd0;
                end else begin
                  phase_d = PH_STOP;
                end
              end
            endcase
          end
        end
        PH_RECV: begin
          if (seg_q == 2'd0) begin
            scl_d = 1'b1;
            seg_d = 2'd1;
          end else begin
            shift_d   = {shift_q[6:0], sda_in_i};
            scl_d     = 1'b0;
            bit_cnt_d = bit_cnt_q + 4'd1;
            seg_d     = 2'd0;
            if (bit_cnt_q == 4'd7) begin
              res_d.read_valid = 1'b1;
              res_d.read_data  = {shift_q[6:0], sda_in_i};
              res_d.read_last  = (left_q <= CntW'(1));
              if (left_q != '0) begin
                left_d = left_q - CntW'(1);
              end
              phase_d = PH_RACK;
            end
          end
        end
        PH_RACK: begin
          if (seg_q == 2'd0) begin
            sda_d = (left_q == '0);
            seg_d = 2'd1;
          end else if (seg_q == 2'd1) begin
            scl_d = 1'b1;
            seg_d = 2'd2;
          end else begin
            scl_d     = 1'b0;
            sda_d     = 1'b1;
            seg_d     = 2'd0;
            bit_cnt_d = 4'd0;
            if (left_q != '0) begin
              phase_d = PH_RECV;
              shift_d = 8'd0;
            end else begin
              phase_d = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          if (seg_q == 2'd0) begin
            sda_d = 1'b0;
            scl_d = 1'b1;
            seg_d = 2'd1;
          end else begin
            sda_d          = 1'b1;
            res_d.done_res = 1'b1;
            res_d.error    = err_q;
            phase_d        = PH_IDLE;
            seg_d          = 2'd0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    res_d.scl_level = scl_d;
    res_d.sda_level = sda_d;
    res_d.busy_res  = (phase_d != PH_IDLE);
  end

  // state, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      stage_q     <= ST_ADDR_W;
      seg_q       <= 2'd0;
      bit_cnt_q   <= 4'd0;
      shift_q     <= 8'd0;
      left_q      <= '0;
      fill_q      <= '0;
      index_q     <= '0;
      is_read_q   <= 1'b0;
      reg_q       <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      err_q       <= 1'b0;
      dev_addr_q  <= i2c_ram_pkg::DEV_ADDR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dev_addr_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q     <= phase_d;
        stage_q     <= stage_d;
        seg_q       <= seg_d;
        bit_cnt_q   <= bit_cnt_d;
        shift_q     <= shift_d;
        left_q      <= left_d;
        fill_q      <= fill_d;
        index_q     <= index_d;
        is_read_q   <= is_read_d;
        reg_q       <= reg_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        err_q       <= err_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule

### tb/i2c_ram_checker.sv
// ----------------------------------------------------------------------------
// i2c_ram_checker - result checker for the i2c register access master
// Watches the command, result and address channels, runs its own bus
// sequencer on every accepted command and compares each result transfer
// field by field against the oldest predicted record.
// ----------------------------------------------------------------------------
module i2c_ram_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command stream as seen at the block
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  // reg_addr[7:0], data_byte[15:8], byte_count[20:16], sda_in[21], zero[23:22]
  input  logic [23:0] s_data_i,
  // op[1:0]
  input  logic [1:0]  s_user_i,
  // result stream as seen at the block
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  // scl_level[0], sda_level[1], busy_res[2], read_valid[3], read_data[11:4],
  // done_res[12], error[13], zero[15:14]
  input  logic [15:0] m_data_i,
  input  logic        m_last_i,
  // device address channel
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [6:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  // bus segment sequencer phases
  typedef enum logic [2:0] {
    BUS_IDLE,
    BUS_START,
    BUS_SEND,
    BUS_SLAVE_ACK,
    BUS_RECV,
    BUS_MASTER_ACK,
    BUS_STOP
  } bus_phase_e;

  // which byte of the transaction is on the bus
  typedef enum logic [2:0] {
    STG_ADDR_W,
    STG_REG,
    STG_DATA,
    STG_ADDR_R,
    STG_READ
  } xfer_stage_e;

  // predicted sequencer state
  logic [6:0]  dev_addr;
  bus_phase_e  phase;
  xfer_stage_e stage;
  logic [3:0]  bit_cnt;
  logic [1:0]  seg;
  logic [7:0]  shreg;
  logic [4:0]  left;
  logic [4:0]  fill;
  logic [4:0]  idx;
  logic        rd_mode;
  logic [7:0]  reg_sel;
  logic        scl;
  logic        sda;
  logic        nack_seen;
  logic [7:0]  wbuf [i2c_ram_pkg::MAX_BYTES_DEF];

  i2c_ram_pkg::result_t expected_q [$];
  i2c_ram_pkg::result_t predicted;
  i2c_ram_pkg::result_t oldest;
  int          fails;
  int          checked;

  task automatic load_byte(input logic [7:0] b);
    phase   = BUS_SEND;
    shreg   = b;
    bit_cnt = '0;
    seg     = '0;
  endtask

  task automatic enter(input bus_phase_e p);
    phase   = p;
    seg     = '0;
    bit_cnt = '0;
    if (p == BUS_RECV) shreg = '0;
  endtask

  // next write data byte, or stop when the count is used up
  task automatic next_write_byte();
    if (left == 0) begin
      enter(BUS_STOP);
    end else begin
      load_byte(wbuf[idx[3:0]]);
      idx++;
      left--;
    end
  endtask

  // one accepted command through the predicted sequencer
  task automatic step_bus(input i2c_ram_pkg::op_e op, input logic [7:0] ra,
                          input logic [7:0] db, input logic [4:0] bc, input logic sda_in,
                          output i2c_ram_pkg::result_t r);
    r = '0;
    if (phase == BUS_IDLE) begin
      case (op)
        i2c_ram_pkg::OP_PUSH: begin
          if (fill < i2c_ram_pkg::MAX_BYTES_DEF) begin
            wbuf[fill[3:0]] = db;
            fill++;
          end
        end
        i2c_ram_pkg::OP_WRITE, i2c_ram_pkg::OP_READ: begin
          if (op == i2c_ram_pkg::OP_WRITE) fill = '0;
          rd_mode   = (op == i2c_ram_pkg::OP_READ);
          reg_sel   = ra;
          left      = (bc > i2c_ram_pkg::MAX_BYTES_DEF) ? 5'(i2c_ram_pkg::MAX_BYTES_DEF) : bc;
          idx       = '0;
          nack_seen = 1'b0;
          stage     = STG_ADDR_W;
          enter(BUS_START);
        end
        default: ;
      endcase
    end else if (op == i2c_ram_pkg::OP_TICK) begin
      case (phase)
        BUS_START: begin
          if (seg == 0) begin
            sda = 1'b1;
            scl = 1'b1;
            seg = 2'd1;
          end else if (seg == 1) begin
            sda = 1'b0;
            seg = 2'd2;
          end else begin
            scl = 1'b0;
            load_byte({dev_addr, stage == STG_ADDR_R});
          end
        end
        BUS_SEND: begin
          if (seg == 0) begin
            sda = shreg[7];
            seg = 2'd1;
          end else if (seg == 1) begin
            scl = 1'b1;
            seg = 2'd2;
          end else begin
            scl = 1'b0;
            // release the line as the last bit clock falls
            if (bit_cnt == 7) sda = 1'b1;
            shreg = {shreg[6:0], 1'b0};
            bit_cnt++;
            seg = '0;
            if (bit_cnt >= 8) enter(BUS_SLAVE_ACK);
          end
        end
        BUS_SLAVE_ACK: begin
          if (seg == 0) begin
            sda = 1'b1;
            seg = 2'd1;
          end else if (seg == 1) begin
            scl = 1'b1;
            seg = 2'd2;
          end else begin
            scl = 1'b0;
            // register and read address acknowledges carry no weight
            case (stage)
              STG_ADDR_W: begin
                if (sda_in) begin
                  nack_seen = 1'b1;
                  enter(BUS_STOP);
                end else begin
                  stage = STG_REG;
                  load_byte(reg_sel);
                end
              end
              STG_REG: begin
                if (rd_mode) begin
                  stage = STG_ADDR_R;
                  enter(BUS_START);
                end else begin
                  stage = STG_DATA;
                  next_write_byte();
                end
              end
              STG_DATA: begin
                if (sda_in) begin
                  nack_seen = 1'b1;
                  enter(BUS_STOP);
                end else begin
                  next_write_byte();
                end
              end
              default: begin
                stage = STG_READ;
                enter(left != 0 ? BUS_RECV : BUS_STOP);
              end
            endcase
          end
        end
        BUS_RECV: begin
          if (seg == 0) begin
            scl = 1'b1;
            seg = 2'd1;
          end else begin
            shreg = {shreg[6:0], sda_in};
            scl   = 1'b0;
            bit_cnt++;
            seg   = '0;
            if (bit_cnt >= 8) begin
              r.read_valid = 1'b1;
              r.read_data  = shreg;
              r.read_last  = (left <= 1);
              if (left != 0) left--;
              phase = BUS_MASTER_ACK;
              seg   = '0;
            end
          end
        end
        BUS_MASTER_ACK: begin
          if (seg == 0) begin
            // ack while bytes remain, nack on the last one
            sda = (left == 0);
            seg = 2'd1;
          end else if (seg == 1) begin
            scl = 1'b1;
            seg = 2'd2;
          end else begin
            scl = 1'b0;
            sda = 1'b1;
            enter(left != 0 ? BUS_RECV : BUS_STOP);
          end
        end
        BUS_STOP: begin
          if (seg == 0) begin
            sda = 1'b0;
            scl = 1'b1;
            seg = 2'd1;
          end else begin
            sda        = 1'b1;
            r.done_res = 1'b1;
            r.error    = nack_seen;
            phase      = BUS_IDLE;
            seg        = '0;
          end
        end
        default: phase = BUS_IDLE;
      endcase
    end
    r.scl_level = scl;
    r.sda_level = sda;
    r.busy_res  = (phase != BUS_IDLE);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // prediction on command transfers, comparison on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr  = i2c_ram_pkg::DEV_ADDR_RESET;
      phase     = BUS_IDLE;
      stage     = STG_ADDR_W;
      bit_cnt   = '0;
      seg       = '0;
      shreg     = '0;
      left      = '0;
      fill      = '0;
      idx       = '0;
      rd_mode   = 1'b0;
      reg_sel   = '0;
      scl       = 1'b1;
      sda       = 1'b1;
      nack_seen = 1'b0;
      foreach (wbuf[i]) wbuf[i] = '0;
      expected_q.delete();
      fails        = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) dev_addr = cfg_data_i;

      if (m_valid_i && m_ready_i) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: result %h/%b arrived with no command outstanding",
                   $time, m_data_i, m_last_i);
        end else begin
          oldest = expected_q.pop_front();
          checked++;
          check_field("scl_level",  32'(oldest.scl_level),  32'(m_data_i[0]));
          check_field("sda_level",  32'(oldest.sda_level),  32'(m_data_i[1]));
          check_field("busy_res",   32'(oldest.busy_res),   32'(m_data_i[2]));
          check_field("read_valid", 32'(oldest.read_valid), 32'(m_data_i[3]));
          check_field("read_data",  32'(oldest.read_data),  32'(m_data_i[11:4]));
          check_field("read_last",  32'(oldest.read_last),  32'(m_last_i));
          check_field("done_res",   32'(oldest.done_res),   32'(m_data_i[12]));
          check_field("error",      32'(oldest.error),      32'(m_data_i[13]));
        end
      end

      if (s_valid_i && s_ready_i) begin
        step_bus(i2c_ram_pkg::op_e'(s_user_i), s_data_i[7:0], s_data_i[15:8],
                 s_data_i[20:16], s_data_i[21], predicted);
        expected_q.push_back(predicted);
      end

      fail_count_o <= fails;
      pending_o    <= expected_q.size();
      checked_o    <= checked;
    end
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of the i2c register access master
// Drives directed and random register write and read transactions, tick by
// tick, with bursty command traffic and a stalling result side, while the
// checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_AFTER     = 300;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned ITEM_TARGET    = 1500;
  // bus segments per piece of a transaction
  localparam int unsigned START_TICKS    = 3;
  localparam int unsigned BYTE_TICKS     = 27;
  localparam int unsigned RECV_TICKS     = 19;
  localparam int unsigned STOP_TICKS     = 2;
  // tick on which the address acknowledge is sampled
  localparam int unsigned ACK_FIRST      = START_TICKS + BYTE_TICKS;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = i2c_ram_pkg::OP_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i    = '0;

  int fail_count;
  int pending;
  int checked;
  int burst_left  = 0;
  int items_sent  = 0;
  int n_reads     = 0;
  int n_writes    = 0;
  int n_nacks     = 0;
  int n_settings  = 0;
  int idle_cycles = 0;
  bit long_hold_done = 1'b0;

  i2c_register_access_master #(
    .MaxBytes(i2c_ram_pkg::MAX_BYTES_DEF)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  i2c_ram_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_last_i    (m_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending);
        $display("** i2c_register_access_master: FAILED **");
        $finish;
      end
    end
  end

  // result side: stall patterns of its own, one long hold-off
  initial begin
    int mode;
    int span;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk_i);
        if (!long_hold_done && checked >= HOLD_AFTER) begin
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          long_hold_done = 1'b1;
        end else begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // one command transfer, in bursts with random gaps
  task automatic send_item(input i2c_ram_pkg::op_e op, input logic [7:0] ra,
                           input logic [7:0] db, input logic [4:0] bc, input logic sda_in);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, sda_in, bc, db, ra};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // new device address, only with the block idle and drained
  task automatic write_address(input logic [6:0] addr);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic push_bytes(input int n);
    repeat (n) begin
      send_item(i2c_ram_pkg::OP_PUSH, 8'($urandom), 8'($urandom), 5'($urandom),
                1'($urandom_range(0, 1)));
    end
  endtask

  // start command plus enough ticks to finish; nack_k < 0 means all acks low,
  // otherwise the acknowledge of byte nack_k modulo (count + 2) (address for reads) is driven high
  task automatic run_transaction(input bit rd, input logic [7:0] ra, input logic [4:0] bc,
                                 input int nack_k);
    int  c;
    int  len;
    int  nack_at;
    bit  slot;
    logic sda_bit;
    c   = (bc > i2c_ram_pkg::MAX_BYTES_DEF) ? int'(i2c_ram_pkg::MAX_BYTES_DEF) : int'(bc);
    len = rd ? 2 * START_TICKS + 3 * BYTE_TICKS + RECV_TICKS * c + STOP_TICKS
             : START_TICKS + BYTE_TICKS * (2 + c) + STOP_TICKS;
    if (nack_k < 0) nack_at = 0;
    else if (rd) nack_at = ACK_FIRST;
    else nack_at = ACK_FIRST + BYTE_TICKS * (nack_k % (c + 2));
    if (rd) n_reads++;
    else n_writes++;
    if (nack_at != 0) n_nacks++;

    send_item(rd ? i2c_ram_pkg::OP_READ : i2c_ram_pkg::OP_WRITE, ra, 8'($urandom), bc,
              1'($urandom_range(0, 1)));
    for (int t = 1; t <= len; t++) begin
      // commands while busy are no-ops; only safe when no early stop is planned
      if (nack_at == 0 && $urandom_range(0, 9) == 0) begin
        send_item(i2c_ram_pkg::op_e'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                  5'($urandom), 1'($urandom_range(0, 1)));
      end
      // acks that decide the outcome; ignored ones and read bits are random
      slot    = rd ? (t == ACK_FIRST)
                   : (t >= ACK_FIRST && (t - ACK_FIRST) % BYTE_TICKS == 0);
      sda_bit = slot ? (t == nack_at) : 1'($urandom_range(0, 1));
      send_item(i2c_ram_pkg::OP_TICK, 8'($urandom), 8'($urandom), 5'($urandom), sda_bit);
    end
    // a few idle ticks, sometimes none so the next start follows the stop
    repeat ($urandom_range(0, 3)) begin
      send_item(i2c_ram_pkg::OP_TICK, 8'($urandom), 8'($urandom), 5'($urandom),
                1'($urandom_range(0, 1)));
    end
  endtask

  // stimulus and verdict
  initial begin
    int          phase_no;
    int          pick;
    int          nack_k;
    bit          rd;
    logic [4:0]  bc;
    logic [6:0]  addr;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ticks while idle change nothing
    send_item(i2c_ram_pkg::OP_TICK, 8'h00, 8'h00, 5'd0, 1'b0);
    send_item(i2c_ram_pkg::OP_TICK, 8'hFF, 8'hFF, 5'd31, 1'b1);
    // fill every buffer entry, then one push beyond full
    send_item(i2c_ram_pkg::OP_PUSH, 8'hFF, 8'h00, 5'd0, 1'b0);
    send_item(i2c_ram_pkg::OP_PUSH, 8'h00, 8'hFF, 5'd31, 1'b1);
    push_bytes(i2c_ram_pkg::MAX_BYTES_DEF - 1);

    // count zero, write and read
    run_transaction(1'b0, 8'hFF, 5'd0, -1);
    run_transaction(1'b1, 8'h00, 5'd0, -1);
    // count above the buffer depth is saturated
    run_transaction(1'b0, 8'hA5, 5'd31, -1);
    // read of a few bytes, nack after the last
    run_transaction(1'b1, 8'h5A, 5'd4, -1);
    // nack on the address byte
    run_transaction(1'b0, 8'h3C, 5'd1, 0);
    // register acknowledge high has no effect
    run_transaction(1'b0, 8'hC3, 5'd1, 1);
    // nack on a data byte
    run_transaction(1'b0, 8'h81, 5'd2, 2);
    // read nack on the address byte
    run_transaction(1'b1, 8'h7E, 5'd1, 0);

    // random phases, each under its own device address
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      phase_no++;
      addr = (phase_no == 1) ? 7'h7F : (phase_no == 2) ? 7'h00 : 7'($urandom);
      write_address(addr);
      repeat ($urandom_range(2, 4)) begin
        if (items_sent < ITEM_TARGET) begin
          rd = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 3) == 0) push_bytes($urandom_range(14, 19));
          else push_bytes($urandom_range(0, 6));
          pick = $urandom_range(0, 99);
          if (pick < 70) bc = 5'($urandom_range(0, 3));
          else if (pick < 90) bc = 5'($urandom_range(4, 8));
          else if (pick < 97) bc = 5'($urandom_range(9, 16));
          else bc = 5'($urandom_range(17, 31));
          nack_k = -1;
          if ($urandom_range(0, 7) == 0) nack_k = $urandom_range(0, 17);
          run_transaction(rd, 8'($urandom), bc, nack_k);
        end
      end
    end

    drain();
    repeat (4) @(posedge clk_i);

    $display("covered %0d writes and %0d reads, %0d with a forced nack, %0d address settings",
             n_writes, n_reads, n_nacks, n_settings);
    $display("%0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("** i2c_register_access_master: PASSED **");
    end else begin
      $display("** i2c_register_access_master: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
sv/i2c_ram_pkg.sv
sv/i2c_ram_wbuf.sv
sv/i2c_ram_fsm.sv
sv/i2c_register_access_master.sv
tb/i2c_ram_checker.sv
tb/tb_top.sv
